### hw/rtl/pleng_pkg.sv
// Shared types and constants of the positional list engine.
package pleng_pkg;

  localparam int unsigned IdxW = 11;

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_DELETE  = 2'd1,
    MODE_READ    = 2'd2,
    MODE_REVERSE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [IdxW-1:0]   idx;
    logic [IdxW-1:0]   lim;
  } cell_cmd_t;

endpackage

### hw/rtl/pleng_cell.sv
// One storage cell of the list chain.
module pleng_cell #(
  parameter int unsigned ValueWidth = 32,
  parameter int unsigned CellIdx    = 0
) (
  input  logic                          clk_i,
  input  pleng_pkg::cell_cmd_t          cmd_i,
  input  logic signed [ValueWidth-1:0]  ins_value_i,
  input  logic signed [ValueWidth-1:0]  left_i,
  input  logic signed [ValueWidth-1:0]  right_i,
  output logic signed [ValueWidth-1:0]  value_o
);

  localparam logic [pleng_pkg::IdxW-1:0] MyIdx = pleng_pkg::IdxW'(CellIdx);

  logic signed [ValueWidth-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    case (cmd_i.op)
      pleng_pkg::CELL_INSERT: begin
        if (MyIdx == cmd_i.idx) begin
          value_d = ins_value_i;
        end else if (MyIdx > cmd_i.idx && MyIdx <= cmd_i.lim) begin
          value_d = left_i;
        end
      end
      pleng_pkg::CELL_DELETE: begin
        if (MyIdx >= cmd_i.idx && MyIdx < cmd_i.lim) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

### hw/rtl/pleng_ctrl.sv
// Request decode, entry count, order flag and result register.
module pleng_ctrl #(
  parameter int unsigned Capacity   = 16,
  parameter int unsigned ValueWidth = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    mode_i,
  input  logic [4:0]                    position_i,
  input  logic signed [ValueWidth-1:0]  cells_i [Capacity],
  output pleng_pkg::cell_cmd_t          cmd_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic signed [31:0]            read_value_o,
  output logic [4:0]                    entry_count_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned AdrW = $clog2(Capacity);
  localparam int unsigned IdxW = pleng_pkg::IdxW;

  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       rev_q, rev_d;
  logic                       out_valid_q, out_valid_d;
  pleng_pkg::status_e         status_q, status_d;
  logic signed [31:0]         read_q, read_d;
  logic [4:0]                 count_q;

  logic                       accept;
  logic [IdxW-1:0]            pos_w, cnt_w, ins_idx, sel_idx;
  logic                       ins_ok, sel_ok, full;
  logic signed [ValueWidth-1:0] sel_value;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign pos_w   = IdxW'(position_i);
  assign cnt_w   = IdxW'(cnt_q);
  assign ins_ok  = (pos_w != '0) && (pos_w <= cnt_w + IdxW'(1));
  assign sel_ok  = (pos_w != '0) && (pos_w <= cnt_w);
  assign full    = (cnt_w == IdxW'(Capacity));
  assign ins_idx = rev_q ? (cnt_w + IdxW'(1) - pos_w) : (pos_w - IdxW'(1));
  assign sel_idx = rev_q ? (cnt_w - pos_w) : (pos_w - IdxW'(1));

  assign sel_value = cells_i[sel_idx[AdrW-1:0]];

  always_comb begin
    cnt_d     = cnt_q;
    rev_d     = rev_q;
    status_d  = pleng_pkg::STATUS_DONE;
    read_d    = '0;
    cmd_o.op  = pleng_pkg::CELL_HOLD;
    cmd_o.idx = ins_idx;
    cmd_o.lim = cnt_w;
    case (pleng_pkg::mode_e'(mode_i))
      pleng_pkg::MODE_INSERT: begin
        if (!ins_ok) begin
          status_d = pleng_pkg::STATUS_INVALID;
        end else if (full) begin
          status_d = pleng_pkg::STATUS_FULL;
        end else begin
          cmd_o.op = pleng_pkg::CELL_INSERT;
          cnt_d    = cnt_q + CntW'(1);
        end
      end
      pleng_pkg::MODE_DELETE: begin
        cmd_o.idx = sel_idx;
        cmd_o.lim = cnt_w - IdxW'(1);
        if (!sel_ok) begin
          status_d = pleng_pkg::STATUS_INVALID;
        end else begin
          cmd_o.op = pleng_pkg::CELL_DELETE;
          cnt_d    = cnt_q - CntW'(1);
        end
      end
      pleng_pkg::MODE_READ: begin
        if (!sel_ok) begin
          status_d = pleng_pkg::STATUS_INVALID;
        end else begin
          read_d = 32'(sel_value);
        end
      end
      default: rev_d = ~rev_q;
    endcase
    if (!accept) begin
      cmd_o.op = pleng_pkg::CELL_HOLD;
      cnt_d    = cnt_q;
      rev_d    = rev_q;
    end
  end

  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      rev_q       <= rev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      read_q   <= read_d;
      count_q  <= 5'(cnt_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_value_o  = read_q;
  assign entry_count_o = count_q;

endmodule

### hw/rtl/positional_list_engine.sv
// Top level of the positional list engine: control and the chain of cells.
//
// Usage: one request item enters on the in channel (mode_i, position_i,
// item_value_i) and exactly one result item leaves on the out channel
// (status_o, read_value_o, entry_count_o). Both channels move an item at a
// clock edge where valid is high and stall is low.
// Result: registered, valid in the cycle after acceptance. Throughput:
// one item per cycle unless stalled. Insert and delete shift every
// affected cell by one place at once across the chain; reverse only flips
// the order flag that maps list positions to cells; read selects one cell.
// The result register decouples the sides: while it holds an item that is
// not taken, in_stall_o follows out_stall_i; when it is taken in the same
// cycle, a new item is accepted at once.
// Reset: the entry count and order flag clear, no result is pending; cell
// contents are undefined until written, and only written cells are read.
// Stall: a stalled result holds its value until taken.
module positional_list_engine #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [4:0]         position_i,
  input  logic signed [31:0] item_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] read_value_o,
  output logic [4:0]         entry_count_o
);

  pleng_pkg::cell_cmd_t          cmd;
  logic signed [VALUE_WIDTH-1:0] cells [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] ins_value;

  assign ins_value = VALUE_WIDTH'(item_value_i);

  pleng_ctrl #(
    .Capacity   (CAPACITY),
    .ValueWidth (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .position_i    (position_i),
    .cells_i       (cells),
    .cmd_o         (cmd),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = cells[i];
    end else begin : g_mid_l
      assign left = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cells[i];
    end else begin : g_mid_r
      assign right = cells[i+1];
    end
    pleng_cell #(
      .ValueWidth (VALUE_WIDTH),
      .CellIdx    (i)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .ins_value_i (ins_value),
      .left_i      (left),
      .right_i     (right),
      .value_o     (cells[i])
    );
  end

endmodule

### hw/rtl/pleng_checker.sv
// Port-level assertions of the positional list engine and their bind.
module pleng_checker #(
  parameter int unsigned Capacity = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         status_o,
  input logic signed [31:0] read_value_o,
  input logic [4:0]         entry_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(read_value_o) && $stable(entry_count_o))
    else $error("stalled result changed");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted item gave no result");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == pleng_pkg::STATUS_FULL |->
      entry_count_o == 5'(Capacity))
    else $error("full status with list not full");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != pleng_pkg::STATUS_DONE |-> read_value_o == '0)
    else $error("failed request returned data");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == pleng_pkg::STATUS_DONE
      || status_o == pleng_pkg::STATUS_INVALID
      || status_o == pleng_pkg::STATUS_FULL)
    else $error("undefined status code");

endmodule

bind positional_list_engine pleng_checker #(.Capacity(CAPACITY)) u_pleng_checker (.*);
